[rtl/core/assert_macros.svh]
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PDR_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("scheduler assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PDR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

[rtl/core/pdr_pkg.sv]
// Types and codes of the priority dispatch scheduler.
`timescale 1ns / 1ps
package pdr_pkg;

    localparam int TYPE_W  = 3;
    localparam int PRIO_W  = 2;
    localparam int METH_W  = 2;
    localparam int ID_W    = 6;
    localparam int EV_W    = 3;
    localparam int SLOT_OW = 6;
    localparam int CNT_OW  = 7;
    localparam int RUN_W   = 5;
    localparam int TRY_W   = 4;
    localparam int CFG_W   = 5;
    localparam int MAX_CONC_LIMIT = 20;
    localparam int RETRY_LIMIT_MAX = 10;
    localparam logic [RUN_W-1:0] MAX_CONC_RESET = 5'd5;
    localparam logic [TRY_W-1:0] RETRY_RESET    = 4'd3;

    // Request codes
    localparam logic [TYPE_W-1:0] REQ_ADD    = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_RUN    = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_PAUSE  = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_SUCC   = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_FAIL   = 3'd4;
    localparam logic [TYPE_W-1:0] REQ_CANCEL = 3'd5;
    localparam logic [TYPE_W-1:0] REQ_CLEAR  = 3'd6;

    // Event codes
    localparam logic [EV_W-1:0] EV_ID       = 3'd0;
    localparam logic [EV_W-1:0] EV_DISPATCH = 3'd1;
    localparam logic [EV_W-1:0] EV_SUCCESS  = 3'd2;
    localparam logic [EV_W-1:0] EV_FAILED   = 3'd3;
    localparam logic [EV_W-1:0] EV_RETRY    = 3'd4;
    localparam logic [EV_W-1:0] EV_ALL_DONE = 3'd5;
    localparam logic [EV_W-1:0] EV_CANCEL   = 3'd6;
    localparam logic [EV_W-1:0] EV_REJECT   = 3'd7;

    // Configuration register indexes
    localparam logic CFG_MAX_CONC = 1'b0;
    localparam logic CFG_RETRY    = 1'b1;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [METH_W-1:0] method;
        logic [TRY_W-1:0]  tries;
        logic [TRY_W-1:0]  limit;
    } entry_t;

    typedef struct packed {
        logic              alloc;
        logic              scan_append;
        logic              scan_rotate;
        logic              set_paused;
        logic              clr_paused;
        logic              finish;
        logic              succ_count;
        logic              fail_final;
        logic              retry;
        logic              dispatch;
        logic              cancel;
        logic              clear_all;
        logic              set_ev;
        logic [EV_W-1:0]   ev_kind;
        logic              ev_slot_zero;
        logic              ev_slot_id;
        logic              emit;
        logic              last;
    } pdr_cmd_t;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic              full;
        logic              all_empty;
        logic              can_dispatch;
        logic              paused;
        logic              id_ok;
        logic              retry_ok;
        logic              scan_left_zero;
        logic              ins_done;
        logic              head_gt;
        logic              out_free;
    } pdr_stat_t;

endpackage

[rtl/core/pdr_datapath.sv]
// Datapath: entry table, pending queue, running set, counters and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pdr_datapath #(
    parameter int TABLE_DEPTH = 64,
    parameter int PRIO_LEVELS = 4,
    parameter int MAX_RUNNING = 20
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic [pdr_pkg::TYPE_W-1:0]    s_req_type,
    input  logic [pdr_pkg::PRIO_W-1:0]    s_priority_req,
    input  logic [pdr_pkg::METH_W-1:0]    s_method,
    input  logic [pdr_pkg::ID_W-1:0]      s_req_id,
    input  logic                          cfg_we,
    input  logic                          cfg_addr,
    input  logic [pdr_pkg::CFG_W-1:0]     cfg_wdata,
    input  pdr_pkg::pdr_cmd_t             cmd,
    output pdr_pkg::pdr_stat_t            stat,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pdr_pkg::EV_W-1:0]      m_event_kind,
    output logic [pdr_pkg::SLOT_OW-1:0]   m_slot_id,
    output logic [pdr_pkg::METH_W-1:0]    m_kind_out,
    output logic [pdr_pkg::CNT_OW-1:0]    m_completed_total,
    output logic [pdr_pkg::CNT_OW-1:0]    m_success_total,
    output logic [pdr_pkg::CNT_OW-1:0]    m_added_total,
    output logic                          m_last
);
    import pdr_pkg::*;

    localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;

    // Entry table memory
    entry_t mem [TABLE_DEPTH];
    entry_t rdata_reg;

    // Pending queue as a ring in memory; the head entry is kept in a register
    logic [SLOT_W-1:0] q_slot_mem [TABLE_DEPTH];
    logic [PRIO_W-1:0] q_prio_mem [TABLE_DEPTH];
    logic [SLOT_W-1:0] q_head_reg, q_head_next;
    logic [CNT_W-1:0]  q_count_reg, q_count_next;
    logic [SLOT_W-1:0] q_head_slot_reg;
    logic [PRIO_W-1:0] q_head_prio_reg;
    logic [SLOT_W-1:0] q_tail;
    logic [SLOT_W-1:0] q_head_inc;
    logic [SLOT_W-1:0] q_head_dec;
    logic              q_we;
    logic [SLOT_W-1:0] q_waddr;
    logic [SLOT_W-1:0] q_wslot;
    logic [PRIO_W-1:0] q_wprio;

    logic [TABLE_DEPTH-1:0] run_mask_reg, run_mask_next;
    logic [RUN_W-1:0]  run_count_reg, run_count_next;
    logic [CNT_W-1:0]  next_slot_reg, next_slot_next;
    logic [CNT_W-1:0]  done_cnt_reg, done_cnt_next;
    logic [CNT_W-1:0]  succ_cnt_reg, succ_cnt_next;
    logic              paused_reg, paused_next;
    logic [RUN_W-1:0]  max_conc_reg;
    logic [TRY_W-1:0]  retry_lim_reg;
    logic [CNT_W-1:0]  scan_left_reg, scan_left_next;
    logic              ins_reg, ins_next;

    // Latched request and pending event
    logic [TYPE_W-1:0] cmd_type_reg;
    logic [PRIO_W-1:0] cmd_prio_reg;
    logic [METH_W-1:0] cmd_meth_reg;
    logic [ID_W-1:0]   cmd_id_reg;
    logic [EV_W-1:0]   ev_kind_reg;
    logic [SLOT_W-1:0] ev_slot_reg;

    logic              out_valid_reg;
    logic [EV_W-1:0]   out_kind_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [METH_W-1:0] out_meth_reg;
    logic [CNT_W-1:0]  out_done_reg, out_succ_reg, out_added_reg;
    logic              out_last_reg;

    logic [PRIO_W-1:0] prio_clamped;
    logic [SLOT_W-1:0] id_slot;
    logic [SLOT_W-1:0] new_slot;
    logic [PRIO_W-1:0] new_prio;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    entry_t            mem_wdata;
    logic              mem_re;
    logic [SLOT_W-1:0] mem_raddr;

    // Ring pointer plus offset, wrapped at the table depth
    function automatic logic [SLOT_W-1:0] wrap_add(input logic [SLOT_W-1:0] base,
                                                   input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(TABLE_DEPTH)) begin
            sum = sum - SUM_W'(TABLE_DEPTH);
        end
        return SLOT_W'(sum);
    endfunction

    assign prio_clamped = (32'(s_priority_req) >= PRIO_LEVELS)
                          ? PRIO_W'(PRIO_LEVELS - 1) : s_priority_req;
    assign id_slot = SLOT_W'(cmd_id_reg);

    assign q_tail     = wrap_add(q_head_reg, q_count_reg);
    assign q_head_inc = wrap_add(q_head_reg, CNT_W'(1));
    assign q_head_dec = (q_head_reg == '0) ? SLOT_W'(TABLE_DEPTH - 1) : q_head_reg - 1'b1;

    // Status toward the controller
    always_comb begin
        stat.req_type       = cmd_type_reg;
        stat.full           = (32'(next_slot_reg) >= TABLE_DEPTH);
        stat.all_empty      = (q_count_reg == '0) && (run_count_reg == '0);
        stat.can_dispatch   = (q_count_reg != '0) && (run_count_reg < max_conc_reg)
                              && (32'(run_count_reg) < MAX_RUNNING);
        stat.paused         = paused_reg;
        stat.id_ok          = (32'(cmd_id_reg) < 32'(next_slot_reg)) && run_mask_reg[id_slot];
        stat.retry_ok       = (rdata_reg.tries < rdata_reg.limit);
        stat.scan_left_zero = (scan_left_reg == '0);
        stat.ins_done       = ins_reg;
        stat.head_gt        = (q_head_prio_reg > cmd_prio_reg);
        stat.out_free       = !out_valid_reg || m_ready;
    end

    // Select value pushed into the queue
    always_comb begin
        if (cmd.retry) begin
            new_slot = id_slot;
            new_prio = rdata_reg.prio;
        end else begin
            new_slot = ev_slot_reg;
            new_prio = cmd_prio_reg;
        end
    end

    // Queue moves: clear, pop, push at head, append at tail, rotate head to tail
    always_comb begin
        q_head_next  = q_head_reg;
        q_count_next = q_count_reg;
        q_we         = 1'b0;
        q_waddr      = q_tail;
        q_wslot      = new_slot;
        q_wprio      = new_prio;
        if (cmd.cancel || cmd.clear_all) begin
            q_count_next = '0;
        end else if (cmd.dispatch) begin
            q_head_next  = q_head_inc;
            q_count_next = q_count_reg - 1'b1;
        end else if (cmd.retry) begin
            q_we         = 1'b1;
            q_waddr      = q_head_dec;
            q_head_next  = q_head_dec;
            q_count_next = q_count_reg + 1'b1;
        end else if (cmd.scan_append) begin
            q_we         = 1'b1;
            q_count_next = q_count_reg + 1'b1;
        end else if (cmd.scan_rotate) begin
            q_we        = 1'b1;
            q_wslot     = q_head_slot_reg;
            q_wprio     = q_head_prio_reg;
            q_head_next = q_head_inc;
        end
    end

    // Queue memory; refresh the head register, taking a same-cycle write to the new head
    always_ff @(posedge aclk) begin
        if (q_we) begin
            q_slot_mem[q_waddr] <= q_wslot;
            q_prio_mem[q_waddr] <= q_wprio;
        end
        if (q_we && (q_waddr == q_head_next)) begin
            q_head_slot_reg <= q_wslot;
            q_head_prio_reg <= q_wprio;
        end else begin
            q_head_slot_reg <= q_slot_mem[q_head_next];
            q_head_prio_reg <= q_prio_mem[q_head_next];
        end
    end

    // Running set, counters and scan state
    always_comb begin
        run_mask_next  = run_mask_reg;
        run_count_next = run_count_reg;
        next_slot_next = next_slot_reg;
        done_cnt_next  = done_cnt_reg;
        succ_cnt_next  = succ_cnt_reg;
        paused_next    = paused_reg;
        scan_left_next = scan_left_reg;
        ins_next       = ins_reg;
        if (cmd.set_paused) begin
            paused_next = 1'b1;
        end
        if (cmd.clr_paused) begin
            paused_next = 1'b0;
        end
        if (cmd.alloc) begin
            next_slot_next = next_slot_reg + 1'b1;
            scan_left_next = q_count_reg;
            ins_next       = 1'b0;
        end
        if (cmd.scan_append) begin
            ins_next = 1'b1;
        end
        if (cmd.scan_rotate) begin
            scan_left_next = scan_left_reg - 1'b1;
        end
        if (cmd.finish) begin
            run_mask_next[id_slot] = 1'b0;
            run_count_next         = run_count_reg - 1'b1;
        end
        if (cmd.dispatch) begin
            run_mask_next[q_head_slot_reg] = 1'b1;
            run_count_next                 = run_count_reg + 1'b1;
        end
        if (cmd.succ_count) begin
            done_cnt_next = done_cnt_reg + 1'b1;
            succ_cnt_next = succ_cnt_reg + 1'b1;
        end
        if (cmd.fail_final) begin
            done_cnt_next = done_cnt_reg + 1'b1;
        end
        if (cmd.cancel || cmd.clear_all) begin
            run_mask_next  = '0;
            run_count_next = '0;
        end
        if (cmd.clear_all) begin
            next_slot_next = '0;
            done_cnt_next  = '0;
            succ_cnt_next  = '0;
        end
    end

    // Memory port selection
    always_comb begin
        mem_we    = cmd.alloc || cmd.retry;
        mem_waddr = cmd.retry ? id_slot : SLOT_W'(next_slot_reg);
        if (cmd.retry) begin
            mem_wdata       = rdata_reg;
            mem_wdata.tries = rdata_reg.tries + 1'b1;
        end else begin
            mem_wdata.prio   = cmd_prio_reg;
            mem_wdata.method = cmd_meth_reg;
            mem_wdata.tries  = '0;
            mem_wdata.limit  = retry_lim_reg;
        end
        mem_re    = cmd.finish || cmd.dispatch;
        mem_raddr = cmd.dispatch ? q_head_slot_reg : id_slot;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_type_reg <= s_req_type;
            cmd_prio_reg <= prio_clamped;
            cmd_meth_reg <= s_method;
            cmd_id_reg   <= s_req_id;
        end
        if (cmd.set_ev) begin
            ev_kind_reg <= cmd.ev_kind;
        end
        if (cmd.alloc) begin
            ev_slot_reg <= SLOT_W'(next_slot_reg);
        end else if (cmd.dispatch) begin
            ev_slot_reg <= q_head_slot_reg;
        end else if (cmd.ev_slot_id || cmd.finish) begin
            ev_slot_reg <= id_slot;
        end else if (cmd.ev_slot_zero) begin
            ev_slot_reg <= '0;
        end
        if (cmd.emit) begin
            out_kind_reg  <= ev_kind_reg;
            out_slot_reg  <= ev_slot_reg;
            out_meth_reg  <= (ev_kind_reg == EV_DISPATCH) ? rdata_reg.method : '0;
            out_done_reg  <= done_cnt_reg;
            out_succ_reg  <= succ_cnt_reg;
            out_added_reg <= next_slot_reg;
            out_last_reg  <= cmd.last;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_head_reg    <= '0;
            q_count_reg   <= '0;
            run_mask_reg  <= '0;
            run_count_reg <= '0;
            next_slot_reg <= '0;
            done_cnt_reg  <= '0;
            succ_cnt_reg  <= '0;
            paused_reg    <= 1'b0;
            scan_left_reg <= '0;
            ins_reg       <= 1'b0;
            max_conc_reg  <= MAX_CONC_RESET;
            retry_lim_reg <= RETRY_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            q_head_reg    <= q_head_next;
            q_count_reg   <= q_count_next;
            run_mask_reg  <= run_mask_next;
            run_count_reg <= run_count_next;
            next_slot_reg <= next_slot_next;
            done_cnt_reg  <= done_cnt_next;
            succ_cnt_reg  <= succ_cnt_next;
            paused_reg    <= paused_next;
            scan_left_reg <= scan_left_next;
            ins_reg       <= ins_next;
            // Drop out-of-range configuration writes
            if (cfg_we) begin
                if (cfg_addr == CFG_MAX_CONC) begin
                    if ((cfg_wdata != '0) && (32'(cfg_wdata) <= MAX_RUNNING)
                        && (32'(cfg_wdata) <= MAX_CONC_LIMIT)) begin
                        max_conc_reg <= RUN_W'(cfg_wdata);
                    end
                end else begin
                    if (32'(cfg_wdata) <= RETRY_LIMIT_MAX) begin
                        retry_lim_reg <= TRY_W'(cfg_wdata);
                    end
                end
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_event_kind      = out_kind_reg;
    assign m_slot_id         = SLOT_OW'(out_slot_reg);
    assign m_kind_out        = out_meth_reg;
    assign m_completed_total = CNT_OW'(out_done_reg);
    assign m_success_total   = CNT_OW'(out_succ_reg);
    assign m_added_total     = CNT_OW'(out_added_reg);
    assign m_last            = out_last_reg;

    `PDR_ASSERT(a_run_count_matches, aclk, aresetn, 32'(run_count_reg) == $countones(run_mask_reg))
    `PDR_ASSERT(a_queue_within_table, aclk, aresetn, q_count_reg <= next_slot_reg)
    `PDR_ASSERT_NEXT(a_emit_fills_output, aclk, aresetn, cmd.emit, out_valid_reg)

endmodule

[rtl/core/pdr_controller.sv]
// Controller: sequences each request through decode, queue scan, dispatch and report.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pdr_controller (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  pdr_pkg::pdr_stat_t stat,
    output pdr_pkg::pdr_cmd_t  cmd,
    output logic               s_ready
);
    import pdr_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_SCAN   = 6'b000100,
        S_FAIL   = 6'b001000,
        S_PASS   = 6'b010000,
        S_REPORT = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   after_pass_reg, after_pass_next;
    logic   pass_quiet;

    // A dispatch pass gives no result when paused, or when nothing can be dispatched while work remains
    assign pass_quiet = stat.paused || !(stat.can_dispatch || stat.all_empty);

    always_comb begin
        cmd             = '0;
        state_next      = state_reg;
        after_pass_next = after_pass_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                priority case (stat.req_type)
                    REQ_ADD: begin
                        cmd.set_ev = 1'b1;
                        if (stat.full) begin
                            cmd.ev_kind      = EV_REJECT;
                            cmd.ev_slot_zero = 1'b1;
                            after_pass_next  = 1'b0;
                            state_next       = S_REPORT;
                        end else begin
                            cmd.ev_kind = EV_ID;
                            cmd.alloc   = 1'b1;
                            state_next  = S_SCAN;
                        end
                    end
                    REQ_RUN: begin
                        if (stat.all_empty) begin
                            state_next = S_IDLE;
                        end else begin
                            cmd.clr_paused = 1'b1;
                            state_next     = S_PASS;
                        end
                    end
                    REQ_PAUSE: begin
                        cmd.set_paused = 1'b1;
                        state_next     = S_IDLE;
                    end
                    REQ_SUCC, REQ_FAIL: begin
                        if (!stat.id_ok) begin
                            cmd.set_ev      = 1'b1;
                            cmd.ev_kind     = EV_REJECT;
                            cmd.ev_slot_id  = 1'b1;
                            after_pass_next = 1'b0;
                            state_next      = S_REPORT;
                        end else if (stat.req_type == REQ_SUCC) begin
                            cmd.finish      = 1'b1;
                            cmd.succ_count  = 1'b1;
                            cmd.set_ev      = 1'b1;
                            cmd.ev_kind     = EV_SUCCESS;
                            after_pass_next = 1'b1;
                            state_next      = S_REPORT;
                        end else begin
                            cmd.finish = 1'b1;
                            state_next = S_FAIL;
                        end
                    end
                    REQ_CANCEL, REQ_CLEAR: begin
                        cmd.cancel       = (stat.req_type == REQ_CANCEL);
                        cmd.clear_all    = (stat.req_type == REQ_CLEAR);
                        cmd.set_ev       = 1'b1;
                        cmd.ev_kind      = EV_CANCEL;
                        cmd.ev_slot_zero = 1'b1;
                        after_pass_next  = 1'b0;
                        state_next       = S_REPORT;
                    end
                    default: begin
                        cmd.set_ev       = 1'b1;
                        cmd.ev_kind      = EV_REJECT;
                        cmd.ev_slot_zero = 1'b1;
                        after_pass_next  = 1'b0;
                        state_next       = S_REPORT;
                    end
                endcase
            end
            S_SCAN: begin
                // Rotate the queue once round, dropping the new slot in front of
                // the first entry with a larger priority number
                if (stat.scan_left_zero) begin
                    cmd.scan_append = !stat.ins_done;
                    after_pass_next = 1'b0;
                    state_next      = S_REPORT;
                end else if (!stat.ins_done && stat.head_gt) begin
                    cmd.scan_append = 1'b1;
                end else begin
                    cmd.scan_rotate = 1'b1;
                end
            end
            S_FAIL: begin
                cmd.set_ev = 1'b1;
                if (stat.retry_ok) begin
                    cmd.retry   = 1'b1;
                    cmd.ev_kind = EV_RETRY;
                end else begin
                    cmd.fail_final = 1'b1;
                    cmd.ev_kind    = EV_FAILED;
                end
                after_pass_next = 1'b1;
                state_next      = S_REPORT;
            end
            S_PASS: begin
                if (stat.paused) begin
                    state_next = S_IDLE;
                end else if (stat.can_dispatch) begin
                    cmd.dispatch    = 1'b1;
                    cmd.set_ev      = 1'b1;
                    cmd.ev_kind     = EV_DISPATCH;
                    after_pass_next = 1'b1;
                    state_next      = S_REPORT;
                end else if (stat.all_empty) begin
                    cmd.set_ev       = 1'b1;
                    cmd.ev_kind      = EV_ALL_DONE;
                    cmd.ev_slot_zero = 1'b1;
                    after_pass_next  = 1'b0;
                    state_next       = S_REPORT;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_REPORT: begin
                // Hold until the result register frees up
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.last   = after_pass_reg ? pass_quiet : 1'b1;
                    state_next = after_pass_reg ? S_PASS : S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            after_pass_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            after_pass_reg <= after_pass_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    `PDR_ASSERT_NEXT(a_accept_decodes, aclk, aresetn, accept, state_reg == S_DECODE)
    `PDR_ASSERT(a_emit_only_when_free, aclk, aresetn, !cmd.emit || stat.out_free)
    `PDR_ASSERT(a_single_queue_move, aclk, aresetn,
        $countones({cmd.dispatch, cmd.retry, cmd.scan_append, cmd.scan_rotate}) <= 1)

endmodule

[rtl/core/priority_dispatch_with_retry.sv]
// Top level of the priority request scheduler with retries.
// Each request is decoded; an add then scans the pending entries and a failure passes a retry check;
// a result is then reported, and after a success, failure or dispatch a further dispatch pass follows.
// Throughput: one request at a time, taken only while the controller is idle; a held result
// stalls the controller until m_ready.
// Reset: synchronous, active low; clears queue, running set, counters, configuration and output valid flag.
`timescale 1ns / 1ps
module priority_dispatch_with_retry #(
    parameter int TABLE_DEPTH = 64,
    parameter int PRIO_LEVELS = 4,
    parameter int MAX_RUNNING = 20
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [pdr_pkg::TYPE_W-1:0]    s_req_type,
    input  logic [pdr_pkg::PRIO_W-1:0]    s_priority_req,
    input  logic [pdr_pkg::METH_W-1:0]    s_method,
    input  logic [pdr_pkg::ID_W-1:0]      s_req_id,
    input  logic                          cfg_we,
    input  logic                          cfg_addr,
    input  logic [pdr_pkg::CFG_W-1:0]     cfg_wdata,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pdr_pkg::EV_W-1:0]      m_event_kind,
    output logic [pdr_pkg::SLOT_OW-1:0]   m_slot_id,
    output logic [pdr_pkg::METH_W-1:0]    m_kind_out,
    output logic [pdr_pkg::CNT_OW-1:0]    m_completed_total,
    output logic [pdr_pkg::CNT_OW-1:0]    m_success_total,
    output logic [pdr_pkg::CNT_OW-1:0]    m_added_total,
    output logic                          m_last
);
    import pdr_pkg::*;

    pdr_cmd_t  cmd;
    pdr_stat_t stat;
    logic      accept;

    // Take a request only when the controller is idle
    assign accept = s_valid && s_ready;

    pdr_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .stat    (stat),
        .cmd     (cmd),
        .s_ready (s_ready)
    );

    pdr_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .PRIO_LEVELS (PRIO_LEVELS),
        .MAX_RUNNING (MAX_RUNNING)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .accept            (accept),
        .s_req_type        (s_req_type),
        .s_priority_req    (s_priority_req),
        .s_method          (s_method),
        .s_req_id          (s_req_id),
        .cfg_we            (cfg_we),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .cmd               (cmd),
        .stat              (stat),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_event_kind      (m_event_kind),
        .m_slot_id         (m_slot_id),
        .m_kind_out        (m_kind_out),
        .m_completed_total (m_completed_total),
        .m_success_total   (m_success_total),
        .m_added_total     (m_added_total),
        .m_last            (m_last)
    );

endmodule
